[rtl/bppcu_pkg.sv]
// Package for the bivariate polynomial position correction unit.
// Holds the number formats, bus types, coefficient tables and arithmetic helpers.
// Depends on nothing; every other file in rtl imports it.
package bppcu_pkg;

	// Number formats.
	localparam int POS_FRAC_BITS   = 8;
	localparam int ANGLE_FRAC_BITS = 16;
	localparam int GUARD_BITS      = 16;
	localparam int FIELD_BITS      = 18;
	localparam int NORM_BITS       = 30;
	localparam int ACC_FRAC        = POS_FRAC_BITS + GUARD_BITS;

	// Polynomial shape.
	localparam int NUM_DEG    = 5;
	localparam int NUM_TERMS  = NUM_DEG * NUM_DEG;
	localparam int DEG_W      = $clog2(NUM_DEG);
	localparam int TERM_IDX_W = $clog2(NUM_TERMS);

	// Datapath widths. A normalized power reaches +2^NORM_BITS, so it needs two extra bits.
	localparam int POW_W  = NORM_BITS + 2;
	localparam int COEF_W = 26;
	localparam int PROD_W = POW_W + COEF_W;
	localparam int ACC_W  = 64;

	localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
	localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
	localparam logic signed [ACC_W-1:0] OUT_MAX = ACC_W'((64'sd1 <<< (FIELD_BITS-1)) - 1);
	localparam logic signed [ACC_W-1:0] OUT_MIN = ACC_W'(-(64'sd1 <<< (FIELD_BITS-1)));

	typedef logic signed [POW_W-1:0]      pow_t;
	typedef logic signed [FIELD_BITS-1:0] field_t;
	typedef logic signed [ACC_W-1:0]      acc_t;

	// Powers of position and angle, with the word's valid flag and its position.
	typedef struct packed {
		logic                            valid;
		field_t                          x;
		logic [NUM_DEG-1:0][POW_W-1:0]   up;
		logic [NUM_DEG-1:0][POW_W-1:0]   vp;
	} pow_bus_t;

	// Running sum of terms, with the word's valid flag and its position.
	typedef struct packed {
		logic   valid;
		field_t x;
		acc_t   acc;
	} acc_bus_t;

	// Coefficient mantissas, indexed by NUM_DEG * angle degree + position degree.
	localparam logic signed [COEF_W-1:0] COEF_M [NUM_TERMS] = '{
		-26'sd18256403, -26'sd30836216, -26'sd24395647,  26'sd20670306,  26'sd31632707,
		 26'sd18690033, -26'sd19270384,  26'sd18404241, -26'sd23175524, -26'sd24220806,
		 26'sd29520048,  26'sd19030416,  26'sd17060638, -26'sd26067961, -26'sd28422167,
		-26'sd21169172,  26'sd21970793,  26'sd20628654, -26'sd23358420,  26'sd27768843,
		-26'sd24703965, -26'sd27294661, -26'sd25935611,  26'sd29832565,  26'sd23660578
	};

	// Fraction bits of each coefficient mantissa.
	localparam logic [6:0] COEF_F [NUM_TERMS] = '{
		7'd30, 7'd37, 7'd46, 7'd52, 7'd61,
		7'd29, 7'd36, 7'd44, 7'd54, 7'd61,
		7'd26, 7'd35, 7'd44, 7'd51, 7'd60,
		7'd36, 7'd42, 7'd48, 7'd58, 7'd66,
		7'd32, 7'd39, 7'd49, 7'd54, 7'd62
	};

	// Rounds a product of two normalized values back to the normalized format, ties up.
	function automatic pow_t rnd_norm(input logic signed [2*POW_W-1:0] prod);
		logic signed [2*POW_W-1:0] t;
		t = (prod + ((2*POW_W)'(1) <<< (NORM_BITS-1))) >>> NORM_BITS;
		return t[POW_W-1:0];
	endfunction

	// Right shift that brings term k into the accumulator format; negative means a left shift.
	function automatic int term_shift(input logic [TERM_IDX_W-1:0] k,
			input logic [DEG_W-1:0] i, input logic [DEG_W-1:0] j);
		int s;
		s = (FIELD_BITS - 1 - POS_FRAC_BITS) * int'(i) +
			(FIELD_BITS - 1 - ANGLE_FRAC_BITS) * int'(j);
		return int'(COEF_F[k]) + NORM_BITS - s - ACC_FRAC;
	endfunction

	// Scales a product into the accumulator format with rounding or saturation.
	function automatic acc_t scale_term(input logic signed [PROD_W-1:0] p, input int r);
		acc_t pe;
		acc_t lim;
		acc_t res;
		int   sh;
		pe  = ACC_W'(p);
		lim = '0;
		sh  = 0;
		if (r >= 62) begin
			res = '0;
		end else if (r > 0) begin
			res = (pe + (ACC_W'(1) <<< (r-1))) >>> r;
		end else if (pe == '0) begin
			res = '0;
		end else begin
			sh = -r;
			if (sh >= 63) begin
				res = (pe > 0) ? ACC_MAX : ACC_MIN;
			end else begin
				lim = ACC_MAX >>> sh;
				if (pe > lim) begin
					res = ACC_MAX;
				end else if (pe < -lim) begin
					res = ACC_MIN;
				end else begin
					res = pe <<< sh;
				end
			end
		end
		return res;
	endfunction

	// Saturating add in the accumulator format.
	function automatic acc_t sat_add(input acc_t a, input acc_t b);
		logic [ACC_W:0] s;
		s = {a[ACC_W-1], a} + {b[ACC_W-1], b};
		if (s[ACC_W] != s[ACC_W-1]) begin
			return s[ACC_W] ? ACC_MIN : ACC_MAX;
		end
		return s[ACC_W-1:0];
	endfunction

	// Saturating subtract in the accumulator format.
	function automatic acc_t sat_sub(input acc_t a, input acc_t b);
		logic [ACC_W:0] s;
		s = {a[ACC_W-1], a} - {b[ACC_W-1], b};
		if (s[ACC_W] != s[ACC_W-1]) begin
			return s[ACC_W] ? ACC_MIN : ACC_MAX;
		end
		return s[ACC_W-1:0];
	endfunction

endpackage

[rtl/bppcu_power_gen.sv]
// Power generator: builds normalized powers 0 to 4 of position and angle in four stages.
// Depends on bppcu_pkg.
module bppcu_power_gen (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	input  bppcu_pkg::field_t            position_x,
	input  bppcu_pkg::field_t            angle_b,
	output bppcu_pkg::pow_bus_t          pow_out
);
	import bppcu_pkg::*;

	logic   vld_s1, vld_s2, vld_s3, vld_s4;
	field_t x_s1, x_s2, x_s3, x_s4;
	pow_t   up1_s1, up1_s2, up1_s3, up1_s4;
	pow_t   vp1_s1, vp1_s2, vp1_s3, vp1_s4;
	pow_t   up2_s2, up2_s3, up2_s4;
	pow_t   vp2_s2, vp2_s3, vp2_s4;
	pow_t   up3_s3, up3_s4;
	pow_t   vp3_s3, vp3_s4;
	pow_t   up4_s4;
	pow_t   vp4_s4;

	logic signed [2*POW_W-1:0] up_sq, vp_sq, up_cu, vp_cu, up_qu, vp_qu;

	// One multiplier per power and operand, each followed by a register.
	assign up_sq = up1_s1 * up1_s1;
	assign vp_sq = vp1_s1 * vp1_s1;
	assign up_cu = up2_s2 * up1_s2;
	assign vp_cu = vp2_s2 * vp1_s2;
	assign up_qu = up3_s3 * up1_s3;
	assign vp_qu = vp3_s3 * vp1_s3;

	// Valid flags move down the stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	// The inputs are scaled to the normalized format, then raised one power per stage.
	always_ff @(posedge clk) begin
		x_s1   <= position_x;
		up1_s1 <= POW_W'(position_x) <<< (NORM_BITS - (FIELD_BITS - 1));
		vp1_s1 <= POW_W'(angle_b) <<< (NORM_BITS - (FIELD_BITS - 1));

		x_s2   <= x_s1;
		up1_s2 <= up1_s1;
		vp1_s2 <= vp1_s1;
		up2_s2 <= rnd_norm(up_sq);
		vp2_s2 <= rnd_norm(vp_sq);

		x_s3   <= x_s2;
		up1_s3 <= up1_s2;
		vp1_s3 <= vp1_s2;
		up2_s3 <= up2_s2;
		vp2_s3 <= vp2_s2;
		up3_s3 <= rnd_norm(up_cu);
		vp3_s3 <= rnd_norm(vp_cu);

		x_s4   <= x_s3;
		up1_s4 <= up1_s3;
		vp1_s4 <= vp1_s3;
		up2_s4 <= up2_s3;
		vp2_s4 <= vp2_s3;
		up3_s4 <= up3_s3;
		vp3_s4 <= vp3_s3;
		up4_s4 <= rnd_norm(up_qu);
		vp4_s4 <= rnd_norm(vp_qu);
	end

	// The zeroth power is the constant one.
	assign pow_out.valid = vld_s4;
	assign pow_out.x     = x_s4;
	assign pow_out.up    = {up4_s4, up3_s4, up2_s4, up1_s4, POW_W'(1) <<< NORM_BITS};
	assign pow_out.vp    = {vp4_s4, vp3_s4, vp2_s4, vp1_s4, POW_W'(1) <<< NORM_BITS};

endmodule

[rtl/bppcu_cell.sv]
// One term cell of the correction chain: forms one polynomial term and adds it to the sum.
// Depends on bppcu_pkg.
module bppcu_cell (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [bppcu_pkg::DEG_W-1:0]  pos_deg,
	input  logic [bppcu_pkg::DEG_W-1:0]  ang_deg,
	input  bppcu_pkg::pow_bus_t          pow_in,
	input  bppcu_pkg::acc_t              acc_in,
	output bppcu_pkg::pow_bus_t          pow_out,
	output bppcu_pkg::acc_bus_t          acc_out
);
	import bppcu_pkg::*;

	logic [TERM_IDX_W-1:0]     k;
	pow_t                      up_sel;
	pow_t                      vp_sel;
	logic signed [2*POW_W-1:0] w_prod;
	logic signed [PROD_W-1:0]  p_prod;

	pow_bus_t                  pow_q;
	logic                      vld_s1, vld_s2, vld_s3, vld_q;
	field_t                    x_s1, x_s2, x_s3, x_q;
	pow_t                      w_s1;
	logic signed [PROD_W-1:0]  p_s2;
	acc_t                      term_s3;
	acc_t                      acc_q;

	// Term index and the two powers that this cell uses.
	assign k      = TERM_IDX_W'(NUM_DEG * int'(ang_deg) + int'(pos_deg));
	assign up_sel = pow_in.up[pos_deg];
	assign vp_sel = pow_in.vp[ang_deg];
	assign w_prod = up_sel * vp_sel;
	assign p_prod = COEF_M[k] * w_s1;

	// The powers are registered once and then move on to the next cell.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pow_q <= '0;
		end else begin
			pow_q <= pow_in;
		end
	end

	// Valid flags of the term pipeline.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_q  <= 1'b0;
		end else begin
			vld_s1 <= pow_in.valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_q  <= vld_s3;
		end
	end

	// Mixed power, coefficient product, scaling, then the saturating add of the term.
	// The incoming sum arrives from the previous cell in the same cycle as term_s3.
	always_ff @(posedge clk) begin
		x_s1    <= pow_in.x;
		w_s1    <= rnd_norm(w_prod);
		x_s2    <= x_s1;
		p_s2    <= p_prod;
		x_s3    <= x_s2;
		term_s3 <= scale_term(p_s2, term_shift(k, pos_deg, ang_deg));
		x_q     <= x_s3;
		acc_q   <= sat_add(acc_in, term_s3);
	end

	assign pow_out       = pow_q;
	assign acc_out.valid = vld_q;
	assign acc_out.x     = x_q;
	assign acc_out.acc   = acc_q;

endmodule

[rtl/bivariate_poly_position_correction_unit.sv]
// Bivariate polynomial position correction unit: corrected_x = x - P(x, b), P of degree 4 by 4.
// Input word: position_x and angle_b, accepted at a rising edge with start high and busy low.
// Result word: corrected_x, shown for exactly one cycle while done is high.
// busy is always low: a new word may be started in every cycle, one word per clock sustained.
// The power generator first raises position and angle to the fourth power with one multiply
// stage per power. The chain of 25 term cells then adds one term per cell; each cell forms its
// sum through its stages s1, s2, s3 and q but passes its powers on through pow_q alone. The
// output registers fin_diff_s1 and out_x_s2 then subtract the sum from the position, round and
// saturate to 18 bits.
// Words leave in the order they were accepted, never reordered or merged.
// Reset clears every valid flag, so no result strobe appears until a word is started.
// The receiver cannot stall the block; each result must be taken in its strobe cycle.
// Depends on bppcu_pkg, bppcu_power_gen and bppcu_cell.
module bivariate_poly_position_correction_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  bppcu_pkg::field_t  position_x,
	input  bppcu_pkg::field_t  angle_b,
	output logic               done,
	output bppcu_pkg::field_t  corrected_x
);
	import bppcu_pkg::*;

	logic     accept;
	pow_bus_t pow_chain [NUM_TERMS+1];
	acc_t     acc_chain [NUM_TERMS+1];
	acc_bus_t cell_out  [NUM_TERMS];
	acc_bus_t sum_last;

	logic     fin_vld_s1;
	acc_t     fin_diff_s1;
	logic     out_vld_s2;
	field_t   out_x_s2;
	acc_t     rnd_sum;
	acc_t     rnd_shr;
	field_t   clamped;

	// The block never holds off a word.
	assign busy   = 1'b0;
	assign accept = start & ~busy;

	// Powers of position and angle.
	bppcu_power_gen u_power_gen (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (accept),
		.position_x (position_x),
		.angle_b    (angle_b),
		.pow_out    (pow_chain[0])
	);

	// Chain of term cells, ordered by term index; the sum starts from zero.
	assign acc_chain[0] = '0;

	for (genvar g = 0; g < NUM_TERMS; g++) begin : g_cell
		bppcu_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.pos_deg (DEG_W'(g % NUM_DEG)),
			.ang_deg (DEG_W'(g / NUM_DEG)),
			.pow_in  (pow_chain[g]),
			.acc_in  (acc_chain[g]),
			.pow_out (pow_chain[g+1]),
			.acc_out (cell_out[g])
		);
		assign acc_chain[g+1] = cell_out[g].acc;
	end

	assign sum_last = cell_out[NUM_TERMS-1];

	// Round to the output format, ties up, and saturate to the field range.
	assign rnd_sum = sat_add(fin_diff_s1, ACC_W'(1) <<< (GUARD_BITS - 1));
	assign rnd_shr = rnd_sum >>> GUARD_BITS;

	always_comb begin
		priority if (rnd_shr > OUT_MAX) begin
			clamped = OUT_MAX[FIELD_BITS-1:0];
		end else if (rnd_shr < OUT_MIN) begin
			clamped = OUT_MIN[FIELD_BITS-1:0];
		end else begin
			clamped = rnd_shr[FIELD_BITS-1:0];
		end
	end

	// Valid flags of the output stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fin_vld_s1 <= 1'b0;
			out_vld_s2 <= 1'b0;
		end else begin
			fin_vld_s1 <= sum_last.valid;
			out_vld_s2 <= fin_vld_s1;
		end
	end

	// Subtract the correction from the position in the accumulator format, then register the result.
	always_ff @(posedge clk) begin
		fin_diff_s1 <= sat_sub(ACC_W'(sum_last.x) <<< GUARD_BITS, sum_last.acc);
		out_x_s2    <= clamped;
	end

	assign done        = out_vld_s2;
	assign corrected_x = out_x_s2;

endmodule
